@@ rtl/aho_corasick_weighted_match_sum_core_assert.svh @@
// Assertion macros for the weighted match sum core.
// Included by the top level only; no other dependencies.
`ifndef AHO_CORASICK_WEIGHTED_MATCH_SUM_CORE_ASSERT_SVH
`define AHO_CORASICK_WEIGHTED_MATCH_SUM_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define ACWMS_HOLDS(label, ck, rstn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ACWMS_NEXT(label, ck, rstn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/acwms_pkg.sv @@
// Shared constants, types and helper functions for the weighted match sum core.
// No dependencies.
package acwms_pkg;

    localparam int NODES      = 4096;
    localparam int NODE_W     = $clog2(NODES);
    localparam int QCNT_W     = NODE_W + 1;
    localparam int ALPHABET   = 26;
    localparam int LETTER_W   = 5;
    localparam int GOTO_DEPTH = NODES * ALPHABET;
    localparam int GOTO_AW    = $clog2(GOTO_DEPTH);
    localparam int LSUM_W     = 24;
    localparam int LEN_W      = 16;
    localparam int ANS_W      = 30;
    localparam int CMD_W      = 2;
    localparam int PROD_W     = LEN_W + 1 + NODE_W;

    localparam logic [ANS_W-1:0] MODULUS = 30'd1000000007;

    localparam logic [CMD_W-1:0] CMD_PATTERN = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BUILD   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TEXT    = 2'd2;

    localparam logic KIND_BUILD = 1'b0;
    localparam logic KIND_TEXT  = 1'b1;

    typedef logic [NODE_W-1:0]   node_t;
    typedef logic [LETTER_W-1:0] letter_t;
    typedef logic [GOTO_AW-1:0]  gaddr_t;
    typedef logic [LSUM_W-1:0]   lsum_t;
    typedef logic [LEN_W-1:0]    len_t;
    typedef logic [ANS_W-1:0]    ans_t;
    typedef logic [CMD_W-1:0]    cmd_t;

    // Row-major slot of the goto table: node * ALPHABET + letter.
    function automatic gaddr_t goto_addr(node_t n, letter_t c);
        return GOTO_AW'(n) * GOTO_AW'(ALPHABET) + GOTO_AW'(c);
    endfunction

    // Modular add of two operands below 2*MODULUS in total.
    function automatic ans_t mod_add(ans_t a, ans_t b);
        logic [ANS_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, MODULUS})
        begin
            s = s - {1'b0, MODULUS};
        end
        return s[ANS_W-1:0];
    endfunction

endpackage

@@ rtl/acwms_if.sv @@
// Valid/ready channel interfaces for the weighted match sum core.
// Depends on acwms_pkg.
interface acwms_in_if;
    logic                 valid;
    logic                 ready;
    acwms_pkg::cmd_t      cmd;
    acwms_pkg::letter_t   letter;
    logic                 last;
    acwms_pkg::len_t      text_len;

    modport source (output valid, output cmd, output letter, output last,
                    output text_len, input ready);
    modport sink   (input valid, input cmd, input letter, input last,
                    input text_len, output ready);
endinterface

interface acwms_out_if;
    logic                 valid;
    logic                 ready;
    logic                 kind;
    acwms_pkg::ans_t      answer;
    logic                 overflow;

    modport source (output valid, output kind, output answer, output overflow,
                    input ready);
    modport sink   (input valid, input kind, input answer, input overflow,
                    output ready);
endinterface

@@ rtl/aho_corasick_weighted_match_sum_core.sv @@
// Aho-Corasick automaton with a weighted match sum over text letters.
// Depends on acwms_pkg, acwms_if.sv and the assertion macro header.
//
//  channel  | dir  | beat contents
//  ---------+------+------------------------------------------
//  cmd_ch   | in   | cmd, letter, last, text_len
//  res_ch   | out  | kind, answer, overflow
//
// After reset the goto slots and node tables are swept to zero; no beat is taken then.
// A pattern letter passes S_P_EVAL and S_P_END (only S_P_END once its pattern is dropped).
// A text letter passes S_T_NODE, S_T_MUL and S_T_SUB; then the shared modular adder doubles
// 16 times and adds once per set bit of (L - i). A last text letter or a build emits from S_EMIT.
// A build visits each root letter, then per queued node and letter fills an empty slot from
// the fail target or links a child. A stalled result holds the block in its emit state.
`include "aho_corasick_weighted_match_sum_core_assert.svh"

module aho_corasick_weighted_match_sum_core (
    input  logic          clk,
    input  logic          rst_n,
    acwms_in_if.sink      cmd_ch,
    acwms_out_if.source   res_ch
);

    typedef enum logic [20:0] {
        S_CLEAR    = 21'h000001,
        S_IDLE     = 21'h000002,
        S_P_EVAL   = 21'h000004,
        S_P_END    = 21'h000008,
        S_T_NODE   = 21'h000010,
        S_T_MUL    = 21'h000020,
        S_T_SUB    = 21'h000040,
        S_T_DBL    = 21'h000080,
        S_T_ADD    = 21'h000100,
        S_T_ACC    = 21'h000200,
        S_B_ROOT   = 21'h000400,
        S_B_ROOT_E = 21'h000800,
        S_B_POP    = 21'h001000,
        S_B_X      = 21'h002000,
        S_B_FX     = 21'h004000,
        S_B_RD1    = 21'h008000,
        S_B_RD2    = 21'h010000,
        S_B_K      = 21'h020000,
        S_B_V      = 21'h040000,
        S_B_KK     = 21'h080000,
        S_EMIT     = 21'h100000
    } state_t;

    // Memories.
    acwms_pkg::node_t goto_mem [acwms_pkg::GOTO_DEPTH];
    acwms_pkg::node_t fail_mem [acwms_pkg::NODES];
    acwms_pkg::node_t mc_mem   [acwms_pkg::NODES];
    acwms_pkg::lsum_t ls_mem   [acwms_pkg::NODES];
    acwms_pkg::node_t q_mem    [acwms_pkg::NODES];

    logic                goto_we, fail_we, mc_we, q_we;
    acwms_pkg::gaddr_t   goto_wa, goto_ra;
    acwms_pkg::node_t    goto_wd, goto_rd;
    acwms_pkg::node_t    fail_wa, fail_ra, fail_wd, fail_rd;
    acwms_pkg::node_t    mc_wa, mc_ra, mc_wd, mc_rd;
    acwms_pkg::lsum_t    ls_wd, ls_rd;
    acwms_pkg::node_t    q_wd, q_rd;

    // Control and data registers.
    state_t                        state_reg, state_next;
    acwms_pkg::gaddr_t             clr_reg, clr_next;
    acwms_pkg::node_t              pn_reg, pn_next;
    acwms_pkg::node_t              plen_reg, plen_next;
    logic                          dropped_reg, dropped_next;
    acwms_pkg::node_t              used_reg, used_next;
    acwms_pkg::node_t              tn_reg, tn_next;
    acwms_pkg::len_t               pos_reg, pos_next;
    acwms_pkg::ans_t               run_reg, run_next;
    logic                          built_reg, built_next;
    logic                          ovf_reg, ovf_next;
    acwms_pkg::letter_t            letter_reg, letter_next;
    logic                          last_reg, last_next;
    acwms_pkg::len_t               len_reg, len_next;
    acwms_pkg::gaddr_t             slot_reg, slot_next;
    acwms_pkg::letter_t            c_reg, c_next;
    logic [acwms_pkg::QCNT_W-1:0]  head_reg, head_next;
    logic [acwms_pkg::QCNT_W-1:0]  tail_reg, tail_next;
    acwms_pkg::node_t              x_reg, x_next;
    acwms_pkg::node_t              fx_reg, fx_next;
    acwms_pkg::node_t              via_reg, via_next;
    acwms_pkg::node_t              k_reg, k_next;
    acwms_pkg::node_t              mcv_reg, mcv_next;
    acwms_pkg::lsum_t              lsv_reg, lsv_next;
    logic [acwms_pkg::PROD_W-1:0]  prod_reg, prod_next;
    acwms_pkg::lsum_t              s_reg, s_next;
    acwms_pkg::len_t               f_reg, f_next;
    acwms_pkg::ans_t               a_reg, a_next;
    acwms_pkg::ans_t               r_reg, r_next;
    logic [3:0]                    bit_reg, bit_next;
    logic                          kind_pend_reg, kind_pend_next;
    logic                          out_valid_reg, out_valid_next;
    logic                          out_kind_reg, out_kind_next;
    acwms_pkg::ans_t               out_answer_reg, out_answer_next;
    logic                          out_ovf_reg, out_ovf_next;

    // Shared modular adder.
    acwms_pkg::ans_t add_a, add_b, add_y;

    assign add_y = acwms_pkg::mod_add(add_a, add_b);

    assign cmd_ch.ready    = (state_reg == S_IDLE);
    assign res_ch.valid    = out_valid_reg;
    assign res_ch.kind     = out_kind_reg;
    assign res_ch.answer   = out_answer_reg;
    assign res_ch.overflow = out_ovf_reg;

    always_ff @(posedge clk)
    begin
        if (goto_we)
        begin
            goto_mem[goto_wa] <= goto_wd;
        end
        goto_rd <= goto_mem[goto_ra];
    end

    always_ff @(posedge clk)
    begin
        if (fail_we)
        begin
            fail_mem[fail_wa] <= fail_wd;
        end
        fail_rd <= fail_mem[fail_ra];
    end

    always_ff @(posedge clk)
    begin
        if (mc_we)
        begin
            mc_mem[mc_wa] <= mc_wd;
            ls_mem[mc_wa] <= ls_wd;
        end
        mc_rd <= mc_mem[mc_ra];
        ls_rd <= ls_mem[mc_ra];
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            q_mem[tail_reg[acwms_pkg::NODE_W-1:0]] <= q_wd;
        end
        q_rd <= q_mem[head_reg[acwms_pkg::NODE_W-1:0]];
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        pn_next         = pn_reg;
        plen_next       = plen_reg;
        dropped_next    = dropped_reg;
        used_next       = used_reg;
        tn_next         = tn_reg;
        pos_next        = pos_reg;
        run_next        = run_reg;
        built_next      = built_reg;
        ovf_next        = ovf_reg;
        letter_next     = letter_reg;
        last_next       = last_reg;
        len_next        = len_reg;
        slot_next       = slot_reg;
        c_next          = c_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        x_next          = x_reg;
        fx_next         = fx_reg;
        via_next        = via_reg;
        k_next          = k_reg;
        mcv_next        = mcv_reg;
        lsv_next        = lsv_reg;
        prod_next       = prod_reg;
        s_next          = s_reg;
        f_next          = f_reg;
        a_next          = a_reg;
        r_next          = r_reg;
        bit_next        = bit_reg;
        kind_pend_next  = kind_pend_reg;
        out_valid_next  = out_valid_reg && !res_ch.ready;
        out_kind_next   = out_kind_reg;
        out_answer_next = out_answer_reg;
        out_ovf_next    = out_ovf_reg;

        goto_we = 1'b0;
        goto_wa = slot_reg;
        goto_wd = '0;
        goto_ra = slot_reg;
        fail_we = 1'b0;
        fail_wa = k_reg;
        fail_wd = via_reg;
        fail_ra = q_rd;
        mc_we   = 1'b0;
        mc_wa   = k_reg;
        mc_wd   = '0;
        ls_wd   = '0;
        mc_ra   = k_reg;
        q_we    = 1'b0;
        q_wd    = goto_rd;
        add_a   = r_reg;
        add_b   = r_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                goto_we = 1'b1;
                goto_wa = clr_reg;
                if (clr_reg < acwms_pkg::GOTO_AW'(acwms_pkg::NODES))
                begin
                    fail_we = 1'b1;
                    fail_wa = clr_reg[acwms_pkg::NODE_W-1:0];
                    fail_wd = '0;
                    mc_we   = 1'b1;
                    mc_wa   = clr_reg[acwms_pkg::NODE_W-1:0];
                end
                clr_next = clr_reg + 1'b1;
                if (clr_reg == acwms_pkg::GOTO_AW'(acwms_pkg::GOTO_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (cmd_ch.valid)
                begin
                    letter_next = cmd_ch.letter;
                    last_next   = cmd_ch.last;
                    len_next    = cmd_ch.text_len;
                    unique case (cmd_ch.cmd)
                        acwms_pkg::CMD_PATTERN:
                        begin
                            if (!built_reg)
                            begin
                                slot_next = acwms_pkg::goto_addr(pn_reg, cmd_ch.letter);
                                goto_ra   = slot_next;
                                if (cmd_ch.letter >= acwms_pkg::LETTER_W'(acwms_pkg::ALPHABET))
                                begin
                                    dropped_next = 1'b1;
                                    state_next   = S_P_END;
                                end
                                else if (dropped_reg)
                                begin
                                    state_next = S_P_END;
                                end
                                else
                                begin
                                    state_next = S_P_EVAL;
                                end
                            end
                        end
                        acwms_pkg::CMD_BUILD:
                        begin
                            if (built_reg)
                            begin
                                kind_pend_next = acwms_pkg::KIND_BUILD;
                                state_next     = S_EMIT;
                            end
                            else
                            begin
                                c_next     = '0;
                                head_next  = '0;
                                tail_next  = '0;
                                state_next = S_B_ROOT;
                            end
                        end
                        acwms_pkg::CMD_TEXT:
                        begin
                            goto_ra    = acwms_pkg::goto_addr(tn_reg, cmd_ch.letter);
                            state_next = S_T_NODE;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_P_EVAL:
            begin
                if (goto_rd == '0)
                begin
                    if ({1'b0, used_reg} + 1'b1 < acwms_pkg::QCNT_W'(acwms_pkg::NODES))
                    begin
                        used_next = used_reg + 1'b1;
                        goto_we   = 1'b1;
                        goto_wd   = used_next;
                        pn_next   = used_next;
                        plen_next = plen_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next     = 1'b1;
                        dropped_next = 1'b1;
                    end
                end
                else
                begin
                    pn_next   = goto_rd;
                    plen_next = plen_reg + 1'b1;
                end
                state_next = S_P_END;
            end

            S_P_END:
            begin
                if (last_reg)
                begin
                    if (!dropped_reg)
                    begin
                        mc_we = 1'b1;
                        mc_wa = pn_reg;
                        mc_wd = acwms_pkg::NODE_W'(1);
                        ls_wd = acwms_pkg::LSUM_W'(plen_reg);
                    end
                    pn_next      = '0;
                    plen_next    = '0;
                    dropped_next = 1'b0;
                end
                state_next = S_IDLE;
            end

            S_T_NODE:
            begin
                // A letter outside the alphabet sends the walk back to the root.
                if (letter_reg < acwms_pkg::LETTER_W'(acwms_pkg::ALPHABET))
                begin
                    tn_next = goto_rd;
                end
                else
                begin
                    tn_next = '0;
                end
                mc_ra      = tn_next;
                state_next = S_T_MUL;
            end

            S_T_MUL:
            begin
                prod_next = acwms_pkg::PROD_W'({1'b0, pos_reg} + 2'd2)
                          * acwms_pkg::PROD_W'(mc_rd);
                s_next    = ls_rd;
                f_next    = (pos_reg < len_reg) ? (len_reg - pos_reg) : '0;
                state_next = S_T_SUB;
            end

            S_T_SUB:
            begin
                add_a      = acwms_pkg::ANS_W'(prod_reg);
                add_b      = acwms_pkg::MODULUS - acwms_pkg::ANS_W'(s_reg);
                a_next     = add_y;
                r_next     = '0;
                bit_next   = 4'd15;
                state_next = S_T_DBL;
            end

            S_T_DBL:
            begin
                r_next = add_y;
                if (f_reg[bit_reg])
                begin
                    state_next = S_T_ADD;
                end
                else if (bit_reg == '0)
                begin
                    state_next = S_T_ACC;
                end
                else
                begin
                    bit_next = bit_reg - 1'b1;
                end
            end

            S_T_ADD:
            begin
                add_b  = a_reg;
                r_next = add_y;
                if (bit_reg == '0)
                begin
                    state_next = S_T_ACC;
                end
                else
                begin
                    bit_next   = bit_reg - 1'b1;
                    state_next = S_T_DBL;
                end
            end

            S_T_ACC:
            begin
                add_a    = run_reg;
                run_next = add_y;
                pos_next = pos_reg + 1'b1;
                if (last_reg)
                begin
                    kind_pend_next = acwms_pkg::KIND_TEXT;
                    state_next     = S_EMIT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            S_B_ROOT:
            begin
                goto_ra    = acwms_pkg::goto_addr('0, c_reg);
                state_next = S_B_ROOT_E;
            end

            S_B_ROOT_E:
            begin
                if (goto_rd != '0 && tail_reg < acwms_pkg::QCNT_W'(acwms_pkg::NODES))
                begin
                    fail_we   = 1'b1;
                    fail_wa   = goto_rd;
                    fail_wd   = '0;
                    q_we      = 1'b1;
                    tail_next = tail_reg + 1'b1;
                end
                if (c_reg == acwms_pkg::LETTER_W'(acwms_pkg::ALPHABET - 1))
                begin
                    state_next = S_B_POP;
                end
                else
                begin
                    c_next     = c_reg + 1'b1;
                    state_next = S_B_ROOT;
                end
            end

            S_B_POP:
            begin
                if (head_reg < tail_reg)
                begin
                    head_next  = head_reg + 1'b1;
                    state_next = S_B_X;
                end
                else
                begin
                    built_next     = 1'b1;
                    kind_pend_next = acwms_pkg::KIND_BUILD;
                    state_next     = S_EMIT;
                end
            end

            S_B_X:
            begin
                x_next     = q_rd;
                c_next     = '0;
                state_next = S_B_FX;
            end

            S_B_FX:
            begin
                fx_next    = fail_rd;
                state_next = S_B_RD1;
            end

            S_B_RD1:
            begin
                goto_ra    = acwms_pkg::goto_addr(fx_reg, c_reg);
                state_next = S_B_RD2;
            end

            S_B_RD2:
            begin
                via_next   = goto_rd;
                slot_next  = acwms_pkg::goto_addr(x_reg, c_reg);
                goto_ra    = slot_next;
                state_next = S_B_K;
            end

            S_B_K:
            begin
                k_next = goto_rd;
                if (goto_rd == '0)
                begin
                    goto_we = 1'b1;
                    goto_wd = via_reg;
                    if (c_reg == acwms_pkg::LETTER_W'(acwms_pkg::ALPHABET - 1))
                    begin
                        state_next = S_B_POP;
                    end
                    else
                    begin
                        c_next     = c_reg + 1'b1;
                        state_next = S_B_RD1;
                    end
                end
                else
                begin
                    fail_we    = 1'b1;
                    fail_wa    = goto_rd;
                    mc_ra      = via_reg;
                    state_next = S_B_V;
                end
            end

            S_B_V:
            begin
                mcv_next   = mc_rd;
                lsv_next   = ls_rd;
                state_next = S_B_KK;
            end

            S_B_KK:
            begin
                mc_we = 1'b1;
                mc_wd = mc_rd + mcv_reg;
                ls_wd = ls_rd + lsv_reg;
                if (tail_reg < acwms_pkg::QCNT_W'(acwms_pkg::NODES))
                begin
                    q_we      = 1'b1;
                    q_wd      = k_reg;
                    tail_next = tail_reg + 1'b1;
                end
                if (c_reg == acwms_pkg::LETTER_W'(acwms_pkg::ALPHABET - 1))
                begin
                    state_next = S_B_POP;
                end
                else
                begin
                    c_next     = c_reg + 1'b1;
                    state_next = S_B_RD1;
                end
            end

            S_EMIT:
            begin
                if (!out_valid_reg || res_ch.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = kind_pend_reg;
                    out_ovf_next    = ovf_reg;
                    out_answer_next = (kind_pend_reg == acwms_pkg::KIND_TEXT) ? run_reg : '0;
                    if (kind_pend_reg == acwms_pkg::KIND_TEXT)
                    begin
                        run_next = '0;
                        tn_next  = '0;
                        pos_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // The state in S_B_K needs the read address of the node's own slot held;
    // mc_ra defaults to k_reg, which covers the second read issued from S_B_V.

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            pn_reg        <= '0;
            plen_reg      <= '0;
            dropped_reg   <= 1'b0;
            used_reg      <= '0;
            tn_reg        <= '0;
            pos_reg       <= '0;
            run_reg       <= '0;
            built_reg     <= 1'b0;
            ovf_reg       <= 1'b0;
            head_reg      <= '0;
            tail_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            pn_reg        <= pn_next;
            plen_reg      <= plen_next;
            dropped_reg   <= dropped_next;
            used_reg      <= used_next;
            tn_reg        <= tn_next;
            pos_reg       <= pos_next;
            run_reg       <= run_next;
            built_reg     <= built_next;
            ovf_reg       <= ovf_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        letter_reg     <= letter_next;
        last_reg       <= last_next;
        len_reg        <= len_next;
        slot_reg       <= slot_next;
        c_reg          <= c_next;
        x_reg          <= x_next;
        fx_reg         <= fx_next;
        via_reg        <= via_next;
        k_reg          <= k_next;
        mcv_reg        <= mcv_next;
        lsv_reg        <= lsv_next;
        prod_reg       <= prod_next;
        s_reg          <= s_next;
        f_reg          <= f_next;
        a_reg          <= a_next;
        r_reg          <= r_next;
        bit_reg        <= bit_next;
        kind_pend_reg  <= kind_pend_next;
        out_kind_reg   <= out_kind_next;
        out_answer_reg <= out_answer_next;
        out_ovf_reg    <= out_ovf_next;
    end

    `ACWMS_HOLDS(a_queue_order, clk, rst_n, 1'b1, head_reg <= tail_reg, "BFS head passed tail")
    `ACWMS_NEXT(a_ovf_sticky, clk, rst_n, ovf_reg, ovf_reg, "overflow flag cleared")
    `ACWMS_HOLDS(a_build_emits, clk, rst_n, $rose(built_reg), state_reg == S_EMIT, "build ended without a result")

endmodule
